// File: hdl/itaf_pkg.sv
`default_nettype none

package itaf_pkg;

   // Operand widths
   localparam int VALUE_W = 64;
   localparam int NARROW_W = 32;

   // Decimal text of a 64-bit value needs at most 20 digits.
   localparam int DEC_DIGITS = 20;
   localparam int DIGITS_W = 4 * DEC_DIGITS;

   // Counter that holds a bit count, a nibble count or a digit count.
   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] CNT_BITS_WIDE = 7'd64;
   localparam logic [CNT_W-1:0] CNT_BITS_NARROW = 7'd32;
   localparam logic [CNT_W-1:0] CNT_NIBS_WIDE = 7'd16;
   localparam logic [CNT_W-1:0] CNT_NIBS_NARROW = 7'd8;
   localparam logic [CNT_W-1:0] CNT_DEC_DIGITS = 7'd20;
   localparam logic [CNT_W-1:0] CNT_ONE = 7'd1;

   // Format commands
   localparam logic [2:0] CMD_BIN = 3'd0;
   localparam logic [2:0] CMD_HEX = 3'd1;
   localparam logic [2:0] CMD_HEXP = 3'd2;
   localparam logic [2:0] CMD_SDEC = 3'd3;
   localparam logic [2:0] CMD_UDEC = 3'd4;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;
   localparam logic [7:0] CHAR_X = 8'h78;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_TEN = 8'd10;

   typedef enum logic [1:0] {
      KIND_BIN,
      KIND_HEX,
      KIND_DEC
   } kind_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      kind_type            kind;
      logic                prefix;
      logic                minus;
      logic                wide;
      logic [VALUE_W-1:0]  word;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_PREFIX_ZERO,
      ST_PREFIX_X,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] code;
      if (nibble >= 4'd10) begin
         code = CHAR_A_LOWER + {4'd0, nibble} - CHAR_TEN;
      end else begin
         code = CHAR_ZERO + {4'd0, nibble};
      end
      return code;
   endfunction

   // Add three to every BCD digit of five or more, ahead of the doubling shift.
   function automatic logic [DIGITS_W-1:0] bcd_adjust(input logic [DIGITS_W-1:0] bcd);
      logic [DIGITS_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return adj;
   endfunction

endpackage

`default_nettype wire

// File: hdl/itaf_front.sv
`default_nettype none

module itaf_front (
   input  wire logic [63:0]        value,
   input  wire logic               wide,
   input  wire logic [2:0]         command,
   output itaf_pkg::item_type      item,
   output logic                    item_ok
);

   logic [63:0] masked;
   logic [63:0] negated;
   logic [63:0] magnitude;
   logic        negative;

   always_comb begin
      masked = wide ? value : {32'd0, value[31:0]};
      negative = wide ? value[63] : value[31];
      negated = ~masked + 64'd1;
      magnitude = wide ? negated : {32'd0, negated[31:0]};

      item.kind = itaf_pkg::KIND_BIN;
      item.prefix = 1'b0;
      item.minus = 1'b0;
      item.wide = wide;
      item.word = masked;
      item_ok = 1'b1;

      case (command)
         itaf_pkg::CMD_BIN: begin
            item.kind = itaf_pkg::KIND_BIN;
         end
         itaf_pkg::CMD_HEX: begin
            item.kind = itaf_pkg::KIND_HEX;
         end
         itaf_pkg::CMD_HEXP: begin
            item.kind = itaf_pkg::KIND_HEX;
            item.prefix = 1'b1;
         end
         itaf_pkg::CMD_SDEC: begin
            item.kind = itaf_pkg::KIND_DEC;
            item.minus = negative;
            item.word = negative ? magnitude : masked;
         end
         itaf_pkg::CMD_UDEC: begin
            item.kind = itaf_pkg::KIND_DEC;
         end
         default: begin
            // Unknown formats print nothing and are dropped here.
            item_ok = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/itaf_queue.sv
`default_nettype none

module itaf_queue #(
   parameter int DEPTH = 2,
   parameter int COUNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire itaf_pkg::item_type  push_item,
   input  wire logic                pop,
   output itaf_pkg::item_type       head,
   output logic                     not_empty,
   output logic                     full,
   output logic [COUNT_W-1:0]       count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   itaf_pkg::item_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      do_push = push && (count_ff != COUNT_FULL);
      do_pop = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + COUNT_W'(do_push) - COUNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full = (count_ff == COUNT_FULL);
   assign count = count_ff;

endmodule

`default_nettype wire

// File: hdl/itaf_back.sv
`default_nettype none

module itaf_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire itaf_pkg::item_type  head,
   input  wire logic                head_valid,
   output logic                     pop,
   output logic                     rsp_strobe,
   output logic [7:0]               rsp_character,
   output logic                     rsp_last
);

   itaf_pkg::state_type               state_ff, state_in;
   itaf_pkg::kind_type                kind_ff, kind_in;
   logic                              minus_ff, minus_in;
   logic                              started_ff, started_in;
   logic [itaf_pkg::DIGITS_W-1:0]     digits_ff, digits_in;
   logic [itaf_pkg::VALUE_W-1:0]      bin_ff, bin_in;
   logic [itaf_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                              strobe_ff, strobe_in;
   logic [7:0]                        char_ff, char_in;
   logic                              last_ff, last_in;

   logic [itaf_pkg::DIGITS_W-1:0]     adjusted;
   logic [3:0]                        top_nib;
   logic                              top_bit;
   logic                              digit_zero;
   logic                              final_unit;
   logic [7:0]                        digit_char;
   logic [itaf_pkg::DIGITS_W-1:0]     loaded_digits;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itaf_pkg::ST_IDLE: begin
            if (head_valid) begin
               case (head.kind)
                  itaf_pkg::KIND_HEX: begin
                     state_in = head.prefix ? itaf_pkg::ST_PREFIX_ZERO : itaf_pkg::ST_DIGITS;
                  end
                  itaf_pkg::KIND_DEC: begin
                     state_in = itaf_pkg::ST_CONVERT;
                  end
                  default: begin
                     state_in = itaf_pkg::ST_DIGITS;
                  end
               endcase
            end
         end
         itaf_pkg::ST_CONVERT: begin
            if (cnt_ff == itaf_pkg::CNT_ONE) begin
               state_in = minus_ff ? itaf_pkg::ST_SIGN : itaf_pkg::ST_DIGITS;
            end
         end
         itaf_pkg::ST_PREFIX_ZERO: begin
            state_in = itaf_pkg::ST_PREFIX_X;
         end
         itaf_pkg::ST_PREFIX_X: begin
            state_in = itaf_pkg::ST_DIGITS;
         end
         itaf_pkg::ST_SIGN: begin
            state_in = itaf_pkg::ST_DIGITS;
         end
         itaf_pkg::ST_DIGITS: begin
            if (cnt_ff == itaf_pkg::CNT_ONE) begin
               state_in = itaf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itaf_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      adjusted = itaf_pkg::bcd_adjust(digits_ff);
      top_nib = digits_ff[itaf_pkg::DIGITS_W-1 -: 4];
      top_bit = digits_ff[itaf_pkg::DIGITS_W-1];
      final_unit = (cnt_ff == itaf_pkg::CNT_ONE);
      if (kind_ff == itaf_pkg::KIND_BIN) begin
         digit_char = itaf_pkg::CHAR_ZERO + {7'd0, top_bit};
         digit_zero = 1'b0;
      end else begin
         digit_char = itaf_pkg::hex_char(top_nib);
         digit_zero = (top_nib == 4'd0);
      end
      if (head.wide) begin
         loaded_digits = {head.word, 16'd0};
      end else begin
         loaded_digits = {head.word[31:0], 48'd0};
      end

      pop = 1'b0;
      kind_in = kind_ff;
      minus_in = minus_ff;
      started_in = started_ff;
      digits_in = digits_ff;
      bin_in = bin_ff;
      cnt_in = cnt_ff;
      strobe_in = 1'b0;
      char_in = char_ff;
      last_in = 1'b0;

      case (state_ff)
         itaf_pkg::ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               kind_in = head.kind;
               minus_in = head.minus;
               started_in = 1'b0;
               case (head.kind)
                  itaf_pkg::KIND_HEX: begin
                     digits_in = loaded_digits;
                     cnt_in = head.wide ? itaf_pkg::CNT_NIBS_WIDE : itaf_pkg::CNT_NIBS_NARROW;
                  end
                  itaf_pkg::KIND_DEC: begin
                     digits_in = '0;
                     bin_in = head.wide ? head.word : {head.word[31:0], 32'd0};
                     cnt_in = head.wide ? itaf_pkg::CNT_BITS_WIDE : itaf_pkg::CNT_BITS_NARROW;
                  end
                  default: begin
                     digits_in = loaded_digits;
                     cnt_in = head.wide ? itaf_pkg::CNT_BITS_WIDE : itaf_pkg::CNT_BITS_NARROW;
                  end
               endcase
            end
         end
         itaf_pkg::ST_CONVERT: begin
            digits_in = {adjusted[itaf_pkg::DIGITS_W-2:0], bin_ff[itaf_pkg::VALUE_W-1]};
            bin_in = {bin_ff[itaf_pkg::VALUE_W-2:0], 1'b0};
            cnt_in = final_unit ? itaf_pkg::CNT_DEC_DIGITS : cnt_ff - itaf_pkg::CNT_ONE;
         end
         itaf_pkg::ST_PREFIX_ZERO: begin
            strobe_in = 1'b1;
            char_in = itaf_pkg::CHAR_ZERO;
         end
         itaf_pkg::ST_PREFIX_X: begin
            strobe_in = 1'b1;
            char_in = itaf_pkg::CHAR_X;
         end
         itaf_pkg::ST_SIGN: begin
            strobe_in = 1'b1;
            char_in = itaf_pkg::CHAR_MINUS;
         end
         itaf_pkg::ST_DIGITS: begin
            // Leading zeros are skipped in hex and decimal, binary prints every bit, and the final digit always prints.
            strobe_in = started_ff || !digit_zero || final_unit;
            char_in = digit_char;
            last_in = final_unit;
            if (!digit_zero) begin
               started_in = 1'b1;
            end
            if (kind_ff == itaf_pkg::KIND_BIN) begin
               digits_in = {digits_ff[itaf_pkg::DIGITS_W-2:0], 1'b0};
            end else begin
               digits_in = {digits_ff[itaf_pkg::DIGITS_W-5:0], 4'd0};
            end
            cnt_in = cnt_ff - itaf_pkg::CNT_ONE;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itaf_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      minus_ff <= minus_in;
      started_ff <= started_in;
      digits_ff <= digits_in;
      bin_ff <= bin_in;
      cnt_ff <= cnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last = last_ff;

endmodule

`default_nettype wire

// File: hdl/integer_to_ascii_formatter.sv
`default_nettype none

// Channel    | Ports                                   | Handshake
// -----------+-----------------------------------------+----------------------------------
// request    | req_value, req_wide, req_command        | taken when start high, busy low
// result     | rsp_character, rsp_last                 | valid for one cycle on rsp_strobe
//
// A request is classified as it is taken and waits in a small queue until the
// emitter is free. Binary text is printed bit by bit, hex text nibble by
// nibble after an optional 0x prefix, and decimal text first runs through
// shift-add-three conversion, then prints a minus sign if needed and walks
// the 20 BCD digits, so a 64-bit decimal costs the most.
// Reset is synchronous and empties the queue and the emitter.
// The receiver cannot stall; busy rises only when the queue is full.

module integer_to_ascii_formatter #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_value,
   input  wire logic        req_wide,
   input  wire logic [2:0]  req_command,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_character,
   output logic             rsp_last
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   itaf_pkg::item_type  front_item;
   logic                front_ok;
   itaf_pkg::item_type  q_head;
   logic                q_not_empty;
   logic                q_full;
   logic [COUNT_W-1:0]  q_count;
   logic                q_push;
   logic                q_pop;

   // The front classifies the request in the cycle it is taken. Requests with
   // an unknown format are accepted but never enter the queue, since they
   // produce no text.
   itaf_front u_front (
      .value   (req_value),
      .wide    (req_wide),
      .command (req_command),
      .item    (front_item),
      .item_ok (front_ok)
   );

   assign busy = q_full;
   assign q_push = start && !busy && front_ok;

   itaf_queue #(
      .DEPTH   (QUEUE_DEPTH),
      .COUNT_W (COUNT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .full      (q_full),
      .count     (q_count)
   );

   // The back runs the decimal conversion and emits at most one character per cycle,
   // none while it converts or skips leading zeros, through a registered output stage.
   itaf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .head_valid    (q_not_empty),
      .pop           (q_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // A queued request without a simultaneous pop grows the queue by one.
   assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (q_count == $past(q_count) + COUNT_W'(1)))
      else $error("queue count did not grow on push");

   // After the final character the emitter is back in idle, so the strobe is low in the cycle after it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result strobe directly after final character");

   // The queue can only fill because a request was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted request");

endmodule

`default_nettype wire

// File: verif/integer_to_ascii_formatter_test.sv
module integer_to_ascii_formatter_test;

   // The formatter treats command codes above unsigned decimal as unknown and
   // emits no characters for them.
   localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN_LAST = 3'd7;

   localparam int RANDOM_FORMATS = 220;
   // The slowest request is a 64-bit decimal and two more may wait in the queue,
   // so this covers any character still on its way at the end.
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_value;
   logic        req_wide;
   logic [2:0]  req_command;
   logic        rsp_strobe;
   logic [7:0]  rsp_character;
   logic        rsp_last;

   // Characters that the accepted requests still have to produce, oldest first.
   text_char_type pending_text[$];
   text_char_type oldest_char;
   int            mismatch_count = 0;
   int            cycle_count = 0;

   always #5 clock = ~clock;

   integer_to_ascii_formatter dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_wide      (req_wide),
      .req_command   (req_command),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // Works out the text of one request and appends its characters to the list
   // of pending characters. The operand is cut to 32 bits in narrow mode before
   // any command looks at it, so the upper half of the value never shows.
   function automatic void predict_text(input logic [63:0] value, input logic wide,
                                        input logic [2:0] command);
      logic [63:0]   mask;
      logic [63:0]   operand;
      logic [63:0]   rest;
      logic [3:0]    nibble;
      logic          started;
      int            nbits;
      logic [7:0]    text[$];
      logic [7:0]    digits[$];
      text_char_type entry;
      mask = wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
      operand = value & mask;
      nbits = wide ? 64 : 32;
      started = 1'b0;
      case (command)
         itaf_pkg::CMD_BIN: begin
            // Every bit of the operand width is printed, leading zeros included.
            for (int k = nbits - 1; k >= 0; k--) begin
               text.push_back(itaf_pkg::CHAR_ZERO + {7'd0, operand[k]});
            end
         end
         itaf_pkg::CMD_HEX, itaf_pkg::CMD_HEXP: begin
            if (command == itaf_pkg::CMD_HEXP) begin
               text.push_back(itaf_pkg::CHAR_ZERO);
               text.push_back(itaf_pkg::CHAR_X);
            end
            if (operand == 64'd0) begin
               text.push_back(itaf_pkg::CHAR_ZERO);
            end else begin
               // Leading zero nibbles are dropped until the first nonzero one.
               for (int k = nbits / 4 - 1; k >= 0; k--) begin
                  nibble = operand[4*k +: 4];
                  if (nibble != 4'd0) begin
                     started = 1'b1;
                  end
                  if (started) begin
                     text.push_back(nibble >= 4'd10
                        ? itaf_pkg::CHAR_A_LOWER + {4'd0, nibble} - itaf_pkg::CHAR_TEN
                        : itaf_pkg::CHAR_ZERO + {4'd0, nibble});
                  end
               end
            end
         end
         itaf_pkg::CMD_SDEC, itaf_pkg::CMD_UDEC: begin
            rest = operand;
            // A negative operand prints a minus sign and its two's complement
            // magnitude. The most negative value maps onto itself, which read
            // as unsigned is exactly the right magnitude.
            if (command == itaf_pkg::CMD_SDEC && operand[nbits-1]) begin
               text.push_back(itaf_pkg::CHAR_MINUS);
               rest = (~operand + 64'd1) & mask;
            end
            // Peel off decimal digits from the bottom; zero still gives one digit.
            do begin
               digits.push_front(itaf_pkg::CHAR_ZERO + 8'(rest % 64'd10));
               rest = rest / 64'd10;
            end while (rest != 64'd0);
            text = {text, digits};
         end
         default: begin
         end
      endcase
      foreach (text[i]) begin
         entry.code = text[i];
         entry.last = (i == text.size() - 1);
         pending_text.push_back(entry);
      end
   endfunction

   // Picks an operand from a mix of shapes: fully random words, tiny values,
   // words with a random number of leading zeros (to stress the zero
   // suppression), sign boundaries, values around powers of ten and small
   // negative numbers.
   function automatic logic [63:0] random_operand();
      logic [63:0] power;
      logic [63:0] operand;
      power = 64'd1;
      case ($urandom_range(0, 5))
         0: operand = {$urandom, $urandom};
         1: operand = 64'($urandom_range(0, 20));
         2: operand = {$urandom, $urandom} >> $urandom_range(0, 63);
         3: begin
            case ($urandom_range(0, 5))
               0: operand = {$urandom, 32'h8000_0000};
               1: operand = {$urandom, 32'h7FFF_FFFF};
               2: operand = 64'h8000_0000_0000_0000;
               3: operand = 64'h7FFF_FFFF_FFFF_FFFF;
               4: operand = 64'hFFFF_FFFF_FFFF_FFFF;
               default: operand = {$urandom, 32'hFFFF_FFFF};
            endcase
         end
         4: begin
            repeat ($urandom_range(0, 19)) power = power * 64'd10;
            operand = power - 64'd1 + 64'($urandom_range(0, 2));
         end
         default: operand = 64'd0 - 64'($urandom_range(1, 1000));
      endcase
      return operand;
   endfunction

   // Offers one request and holds it until the formatter takes it. The request
   // is taken at the first rising edge where start is high and busy was low, and
   // its expected text is booked right then.
   task automatic send_request(input logic [63:0] value, input logic wide,
                               input logic [2:0] command);
      req_value <= value;
      req_wide <= wide;
      req_command <= command;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_text(value, wide, command);
   endtask

   // Leaves the request channel idle for a number of cycles.
   task automatic pause_requests(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic test_binary();
      send_request(64'd0, 1'b0, itaf_pkg::CMD_BIN);
      // The upper half is junk and must not appear in narrow mode.
      send_request(64'hA5A5_A5A5_FFFF_FFFF, 1'b0, itaf_pkg::CMD_BIN);
      send_request(64'h8000_0000_0000_0001, 1'b1, itaf_pkg::CMD_BIN);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, itaf_pkg::CMD_BIN);
      pause_requests(3);
   endtask

   task automatic test_hex();
      send_request(64'd0, 1'b0, itaf_pkg::CMD_HEX);
      send_request(64'd0, 1'b1, itaf_pkg::CMD_HEXP);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, itaf_pkg::CMD_HEX);
      send_request(64'hDEAD_BEEF_0000_00A0, 1'b0, itaf_pkg::CMD_HEXP);
      send_request(64'h0123_4567_89AB_CDEF, 1'b1, itaf_pkg::CMD_HEXP);
      // A narrow zero with a nonzero upper half still prints a single zero.
      send_request(64'hFFFF_FFFF_0000_0000, 1'b0, itaf_pkg::CMD_HEX);
      pause_requests(3);
   endtask

   task automatic test_decimal();
      // The most negative operand of each width.
      send_request(64'h0000_0000_8000_0000, 1'b0, itaf_pkg::CMD_SDEC);
      send_request(64'h8000_0000_0000_0000, 1'b1, itaf_pkg::CMD_SDEC);
      // Minus one in both widths, the narrow one with junk above.
      send_request(64'h1234_5678_FFFF_FFFF, 1'b0, itaf_pkg::CMD_SDEC);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, itaf_pkg::CMD_SDEC);
      send_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, itaf_pkg::CMD_SDEC);
      send_request(64'd0, 1'b1, itaf_pkg::CMD_SDEC);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, itaf_pkg::CMD_UDEC);
      send_request(64'd10000000000000000000, 1'b1, itaf_pkg::CMD_UDEC);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, itaf_pkg::CMD_UDEC);
      send_request(64'd0, 1'b0, itaf_pkg::CMD_UDEC);
      pause_requests(3);
   endtask

   // Unknown commands must be taken and dropped without a single character;
   // the valid request behind them checks that nothing leaked out.
   task automatic test_unknown_commands();
      for (int code = CMD_UNKNOWN_FIRST; code <= CMD_UNKNOWN_LAST; code++) begin
         send_request({$urandom, $urandom}, 1'($urandom_range(0, 1)), 3'(code));
      end
      send_request(64'd42, 1'b0, itaf_pkg::CMD_UDEC);
      pause_requests(3);
   endtask

   // Random requests in bursts of random length. Most bursts are short with
   // gaps of varied length, so gaps land on every stage of the conversion; some
   // bursts are long, which keeps the queue full and busy high for a while.
   // Unknown commands are mixed in but do not count toward the total.
   task automatic test_random_requests();
      int         formats_sent;
      int         burst_left;
      logic [2:0] command;
      formats_sent = 0;
      burst_left = 0;
      while (formats_sent < RANDOM_FORMATS) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
            if ($urandom_range(0, 3) != 0) begin
               pause_requests(($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                          : $urandom_range(1, 100));
            end
         end
         if ($urandom_range(0, 15) == 0) begin
            command = 3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
         end else begin
            command = 3'($urandom_range(itaf_pkg::CMD_BIN, itaf_pkg::CMD_UDEC));
         end
         send_request(random_operand(), 1'($urandom_range(0, 1)), command);
         if (command <= itaf_pkg::CMD_UDEC) begin
            formats_sent++;
         end
         burst_left--;
      end
   endtask

   // Every strobed character is compared with the oldest pending one. The
   // receiver cannot hold results off, so each strobe is taken as it comes.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_text.size() == 0) begin
            $display("%0t: character %h (last %b) with no request pending",
                     $time, rsp_character, rsp_last);
            mismatch_count++;
         end else begin
            oldest_char = pending_text.pop_front();
            if (rsp_character !== oldest_char.code) begin
               $display("%0t: character expected %h, got %h",
                        $time, oldest_char.code, rsp_character);
               mismatch_count++;
            end
            if (rsp_last !== oldest_char.last) begin
               $display("%0t: last flag expected %b, got %b",
                        $time, oldest_char.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung formatter or a lost handshake ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_value <= 64'd0;
      req_wide <= 1'b0;
      req_command <= itaf_pkg::CMD_BIN;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_binary();
      test_hex();
      test_decimal();
      test_unknown_commands();
      test_random_requests();

      // Drain: wait for every pending character, then watch a while longer
      // for stray strobes.
      start <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
